FILE: design/swds_pkg.sv
// Shared constants for the sliding window distance statistics block.
package swds_pkg;

  localparam int RAW_W      = 10;
  localparam int DIST_W     = 11;
  localparam int DIR_W      = 3;
  localparam int MEAN_W     = 15;
  localparam int DEV_W      = 14;
  localparam int TREND_W    = 15;
  localparam int DELTA_W    = 16;
  localparam int FRAC_W     = 4;
  localparam int SCALE      = 5;
  localparam int DIST_MAX   = 2000;
  localparam int WINDOW_DEF = 8;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

endpackage

FILE: design/swds_ram.sv
// Generic simple dual port RAM with registered read.
module swds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/swds_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module swds_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             qbit;

  always_comb begin
    trial   = {rem_r, q_r[NUM_W-1]};
    diff    = trial - {1'b0, den_r};
    qbit    = (trial >= {1'b0, den_r});
    q_nxt   = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(NUM_W);
    end else if (cnt_r != '0) begin
      q_nxt   = {q_r[NUM_W-2:0], qbit};
      rem_nxt = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = q_r;

endmodule

FILE: design/swds_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module swds_sqrt #(
  parameter int IN_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [IN_W-1:0]   radicand,
  output logic              busy,
  output logic [IN_W/2-1:0] root
);

  logic [IN_W-1:0] x_r, x_nxt;
  logic [IN_W-1:0] root_r, root_nxt;
  logic [IN_W-1:0] bit_r, bit_nxt;
  logic [IN_W:0]   t;

  always_comb begin
    t        = {1'b0, root_r} + {1'b0, bit_r};
    x_nxt    = x_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    if (start) begin
      x_nxt    = radicand;
      root_nxt = '0;
      bit_nxt  = {2'b01, {(IN_W-2){1'b0}}};
    end else if (bit_r != '0) begin
      if ({1'b0, x_r} >= t) begin
        x_nxt    = x_r - t[IN_W-1:0];
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else begin
      bit_r <= bit_nxt;
    end
    x_r    <= x_nxt;
    root_r <= root_nxt;
  end

  assign busy = (bit_r != '0);
  assign root = root_r[IN_W/2-1:0];

endmodule

FILE: design/sliding_window_distance_stats_top.sv
// Flow: a sample word goes through the history reads, the sum update, the products, then the
//   bit-serial divider (mean, then variance) and the root after it; DIV_W = clog2(WINDOW+1) +
//   clog2(WINDOW*2000^2+1) + 8, SQIN_W = DIV_W rounded up to even.
// Input: no new word is taken until the previous sample's result is loaded into the output
//   registers, which waits while out_stall holds the last result; a clear word starts no sequence.
// Reset (synchronous): window empty, sums zero, direction 0; history RAM is not cleared.
module sliding_window_distance_stats_top #(
  parameter int WINDOW = swds_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic [swds_pkg::RAW_W-1:0]          in_raw_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [swds_pkg::DIR_W-1:0]          out_direction,
  output logic [swds_pkg::DIST_W-1:0]         out_distance,
  output logic [swds_pkg::MEAN_W-1:0]         out_window_mean,
  output logic [swds_pkg::DEV_W-1:0]          out_window_deviation,
  output logic signed [swds_pkg::TREND_W-1:0] out_trend,
  output logic signed [swds_pkg::DELTA_W-1:0] out_deviation_from_mean,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swds_pkg::DIR_W-1:0]          cfg_data
);

  localparam int DIST_W  = swds_pkg::DIST_W;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int SUM_W   = $clog2(WINDOW * swds_pkg::DIST_MAX + 1);
  localparam int SQ_W    = $clog2(WINDOW * swds_pkg::DIST_MAX * swds_pkg::DIST_MAX + 1);
  localparam int NSQ_W   = CNT_W + SQ_W;
  localparam int DIV_W   = NSQ_W + 2 * swds_pkg::FRAC_W;
  localparam int DEN_W   = 2 * CNT_W;
  localparam int SQIN_W  = DIV_W + (DIV_W % 2);
  localparam int PROD_W  = 2 * DIST_W;
  localparam int SCL_W   = swds_pkg::RAW_W + 3;
  localparam int DIFF_W  = DIST_W + 1;
  localparam int TMAG_W  = DIST_W + swds_pkg::FRAC_W;
  // trend magnitude / WINDOW as a multiply by a rounded-up reciprocal, exact for TMAG_W bits
  localparam int RCP_SH  = TMAG_W + $clog2(WINDOW);
  localparam int RCP_M   = ((1 << RCP_SH) + WINDOW - 1) / WINDOW;
  localparam int RCP_W   = TMAG_W + 2;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RD1     = 4'd1;
  localparam logic [3:0] S_RD2     = 4'd2;
  localparam logic [3:0] S_UPD     = 4'd3;
  localparam logic [3:0] S_MUL     = 4'd4;
  localparam logic [3:0] S_DM_GO   = 4'd5;
  localparam logic [3:0] S_DM_WAIT = 4'd6;
  localparam logic [3:0] S_DV_GO   = 4'd7;
  localparam logic [3:0] S_DV_WAIT = 4'd8;
  localparam logic [3:0] S_SQ_WAIT = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  logic [3:0]          state_r, state_nxt;
  logic [swds_pkg::DIR_W-1:0] dir_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SQ_W-1:0]     sq_r;
  logic [DIST_W-1:0]   dist_r;
  logic [DIST_W-1:0]   old_r;
  logic [DIST_W-1:0]   oldest_r;
  logic [PROD_W-1:0]   old_sq_r;
  logic [PROD_W-1:0]   new_sq_r;
  logic [NSQ_W-1:0]    nsq_r;
  logic [NSQ_W-1:0]    ssq_r;
  logic [NSQ_W-1:0]    num_r;
  logic [DEN_W-1:0]    nn_r;
  logic [swds_pkg::MEAN_W-1:0] mean_r;
  logic                tneg_r;
  logic [TMAG_W-1:0]   tmag_r;
  logic                out_valid_r;

  logic                accept;
  logic                full;
  logic [SLOT_W-1:0]   slot_inc;
  logic [SCL_W-1:0]    scaled;
  logic [DIST_W-1:0]   dist_w;
  logic [SUM_W:0]      sum_w;
  logic [SQ_W:0]       sq_w;
  logic [NSQ_W-1:0]    nsq_w;
  logic [2*SUM_W-1:0]  ssq_w;
  logic [DEN_W-1:0]    nn_w;
  logic signed [DIFF_W-1:0] tdiff;
  logic [DIFF_W-1:0]   tabs;
  logic [TMAG_W+RCP_W-1:0] tprod;
  logic                out_load;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_raddr;
  logic [DIST_W-1:0]   ram_rdata;

  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [DEN_W-1:0]    div_divisor;
  logic                div_busy;
  logic [DIV_W-1:0]    div_quot;

  logic                sqrt_start;
  logic                sqrt_busy;
  logic [SQIN_W/2-1:0] sqrt_root;

  logic [swds_pkg::TREND_W-1:0] tq;
  logic [swds_pkg::DELTA_W:0]   delta_w;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign full      = (cnt_r == CNT_W'(WINDOW));
  assign slot_inc  = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;

  assign scaled = SCL_W'(in_raw_sample) * SCL_W'(swds_pkg::SCALE);
  assign dist_w = (scaled > SCL_W'(swds_pkg::DIST_MAX)) ? DIST_W'(swds_pkg::DIST_MAX)
                                                         : scaled[DIST_W-1:0];

  // slot is read first (the value leaving), then slot+1 (oldest after the push)
  assign ram_raddr = (state_r == S_RD1) ? slot_inc : slot_r;
  assign ram_we    = (state_r == S_RD2);

  swds_ram #(
    .WIDTH(DIST_W),
    .DEPTH(WINDOW)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_r),
    .wdata(dist_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    sum_w = {1'b0, sum_r} - (full ? (SUM_W+1)'(old_r) : '0) + (SUM_W+1)'(dist_r);
    sq_w  = {1'b0, sq_r} - (full ? (SQ_W+1)'(old_sq_r) : '0) + (SQ_W+1)'(new_sq_r);
    nsq_w = cnt_r * sq_r;
    ssq_w = sum_r * sum_r;
    nn_w  = cnt_r * cnt_r;
    tdiff = $signed({1'b0, dist_r}) - $signed({1'b0, oldest_r});
    tabs  = tdiff[DIFF_W-1] ? DIFF_W'(-tdiff) : DIFF_W'(tdiff);
  end

  // shared divider: mean, then variance
  always_comb begin
    div_start = (state_r == S_DM_GO) || (state_r == S_DV_GO);
    if (state_r == S_DM_GO) begin
      div_dividend = DIV_W'({sum_r, {swds_pkg::FRAC_W{1'b0}}});
      div_divisor  = DEN_W'(cnt_r);
    end else begin
      div_dividend = {num_r, {(2*swds_pkg::FRAC_W){1'b0}}};
      div_divisor  = nn_r;
    end
  end

  assign sqrt_start = (state_r == S_DV_WAIT) && !div_busy;

  swds_div #(
    .NUM_W(DIV_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .busy    (div_busy),
    .quotient(div_quot)
  );

  swds_sqrt #(
    .IN_W(SQIN_W)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sqrt_start),
    .radicand(SQIN_W'(div_quot)),
    .busy    (sqrt_busy),
    .root    (sqrt_root)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (accept && in_kind == swds_pkg::KIND_SAMPLE) state_nxt = S_RD1;
      S_RD1:     state_nxt = S_RD2;
      S_RD2:     state_nxt = S_UPD;
      S_UPD:     state_nxt = S_MUL;
      S_MUL:     state_nxt = S_DM_GO;
      S_DM_GO:   state_nxt = S_DM_WAIT;
      S_DM_WAIT: if (!div_busy) state_nxt = S_DV_GO;
      S_DV_GO:   state_nxt = S_DV_WAIT;
      S_DV_WAIT: if (!div_busy) state_nxt = S_SQ_WAIT;
      S_SQ_WAIT: if (!sqrt_busy) state_nxt = S_FIN;
      S_FIN:     if (out_load) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  assign tprod   = tmag_r * RCP_W'(RCP_M);
  assign tq      = swds_pkg::TREND_W'(tprod >> RCP_SH);
  assign delta_w = {2'b00, dist_r, {swds_pkg::FRAC_W{1'b0}}} - {2'b00, mean_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dir_r       <= '0;
      cnt_r       <= '0;
      slot_r      <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        dir_r <= cfg_data;
      end
      if (accept && in_kind == swds_pkg::KIND_CLEAR) begin
        cnt_r  <= '0;
        slot_r <= '0;
        sum_r  <= '0;
        sq_r   <= '0;
      end
      if (state_r == S_UPD) begin
        sum_r  <= sum_w[SUM_W-1:0];
        sq_r   <= sq_w[SQ_W-1:0];
        slot_r <= slot_inc;
        if (!full) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dist_r <= dist_w;
    end
    if (state_r == S_RD1) begin
      old_r <= ram_rdata;
    end
    if (state_r == S_RD2) begin
      oldest_r <= ram_rdata;
      old_sq_r <= old_r * old_r;
      new_sq_r <= dist_r * dist_r;
    end
    if (state_r == S_UPD) begin
      tneg_r <= tdiff[DIFF_W-1];
      tmag_r <= {tabs[DIST_W-1:0], {swds_pkg::FRAC_W{1'b0}}};
    end
    if (state_r == S_MUL) begin
      nsq_r <= nsq_w;
      ssq_r <= NSQ_W'(ssq_w);
      nn_r  <= nn_w;
    end
    if (state_r == S_DM_GO) begin
      num_r <= nsq_r - ssq_r;
    end
    if (state_r == S_DM_WAIT && !div_busy) begin
      mean_r <= swds_pkg::MEAN_W'(div_quot);
    end
    if (out_load) begin
      out_direction        <= dir_r;
      out_distance         <= dist_r;
      out_window_mean      <= mean_r;
      out_window_deviation <= swds_pkg::DEV_W'(sqrt_root);
      if (full) begin
        out_trend               <= tneg_r ? $signed(-tq) : $signed(tq);
        out_deviation_from_mean <= $signed(delta_w[swds_pkg::DELTA_W-1:0]);
      end else begin
        out_trend               <= '0;
        out_deviation_from_mean <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule
